// ===== rtl/bbb_pkg.sv =====
// ----------------------------------------------------------------------------
// bbb_pkg
// Shared types, codes and constants of the 3x3 box blur blend filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbb_pkg;

    // default geometry limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // item kinds carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // register map (word index)
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_STRENGTH = 2'd2;

    // register fields and reset values
    localparam int         DIM_W        = 11;
    localparam int         STR_W        = 6;
    localparam logic [DIM_W-1:0] WIDTH_RST    = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST   = 11'd480;
    localparam logic [STR_W-1:0] STRENGTH_RST = 6'd1;

    // channel sums and reciprocal divide
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 18;
    localparam int PIX_MAX     = 255;

    // ceil(2^18 / n): exact truncated quotient for sums below 2296
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                4'd1:    r = 19'd262144;
                4'd2:    r = 19'd131072;
                4'd3:    r = 19'd87382;
                4'd4:    r = 19'd65536;
                4'd5:    r = 19'd52429;
                4'd6:    r = 19'd43691;
                4'd7:    r = 19'd37450;
                4'd8:    r = 19'd32768;
                4'd9:    r = 19'd29128;
                default: r = 19'd262144;
            endcase
            return r;
        end
    endfunction

    // control from the sequencer to each channel lane
    typedef struct packed {
        logic                    clr;
        logic                    acc;
        logic                    centre;
        logic                    div_en;
        logic [RECIP_W-1:0]      recip;
        logic signed [STR_W-1:0] strength;
    } lane_ctl_t;

endpackage

// ===== rtl/bbb_ram.sv =====
// ----------------------------------------------------------------------------
// bbb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2052
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bbb_lane.sv =====
// ----------------------------------------------------------------------------
// bbb_lane
// One colour channel: neighbourhood sum, reciprocal divide and blend/clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbb_lane (
    input  logic              clk,
    input  bbb_pkg::lane_ctl_t ctl,
    input  logic [7:0]        tap,
    output logic [7:0]        result
);

    logic [bbb_pkg::SUM_W-1:0]                     sum_reg;
    logic [7:0]                                    centre_reg;
    logic [7:0]                                    avg_reg;
    logic [bbb_pkg::SUM_W+bbb_pkg::RECIP_W-1:0]    quot;
    logic signed [8:0]                             diff;
    logic signed [14:0]                            prod;
    logic signed [15:0]                            blend;

    // accumulate taps, then divide by multiplying with the reciprocal
    assign quot = ctl.recip * sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            sum_reg <= '0;
        end
        else if (ctl.acc)
        begin
            sum_reg <= sum_reg + bbb_pkg::SUM_W'(tap);
        end
        if (ctl.centre)
        begin
            centre_reg <= tap;
        end
        if (ctl.div_en)
        begin
            avg_reg <= quot[bbb_pkg::RECIP_SHIFT +: 8];
        end
    end

    // centre + (mean - centre) * strength, clamped to a byte
    assign diff  = $signed({1'b0, avg_reg}) - $signed({1'b0, centre_reg});
    assign prod  = diff * ctl.strength;
    assign blend = $signed({8'd0, centre_reg}) + 16'(prod);

    always_comb
    begin
        if (blend < 0)
        begin
            result = '0;
        end
        else if (blend > 16'(bbb_pkg::PIX_MAX))
        begin
            result = 8'(bbb_pkg::PIX_MAX);
        end
        else
        begin
            result = blend[7:0];
        end
    end

endmodule

// ===== rtl/box_blur_blend_3x3.sv =====
// ----------------------------------------------------------------------------
// box_blur_blend_3x3
// Streaming 3x3 box-mean blend filter for RGBA pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input beats: tuser = operation (0 pixel, 1 drain), tdata =
//   red/green/blue/alpha. m_* carries results with tlast = frame_end. Pixel
//   number p of a frame releases result p-width-1; once the frame is in,
//   drain beats release the remaining results one each. Geometry is latched
//   on the first pixel of a frame; pixels past a full frame are dropped.
//   Config via the APB port (width at 0x0, height at 0x4, strength at 0x8).
// Sequence:
//   A pixel that releases no result is taken while the block stays idle. An
//   item that releases a result is accepted, then its nine taps are read one
//   after another through the line store's single read port, followed by a
//   step for the registered read data, the divide step and the output load;
//   s_tready stays low until that load. The three colour lanes work side by
//   side.
// Reset: counters clear, registers return to 640 x 480, strength 1; the line
//   store is not cleared (only entries of the current frame are read).
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and holds only when its own result is ready to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_blend_3x3 #(
    parameter int MAX_WIDTH  = bbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbb_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic        s_tuser,   // operation
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_tlast,   // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RING = 2 * MAX_WIDTH + 4;
    localparam int AW   = $clog2(RING);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SW   = AW + 2;
    localparam int DW   = bbb_pkg::DIM_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_OUT} state_t;

    // configuration registers
    logic [DW-1:0]            width_reg;
    logic [DW-1:0]            height_reg;
    logic [bbb_pkg::STR_W-1:0] strength_reg;
    logic                     cfg_wr;

    // frame state
    state_t                   state_reg;
    logic [WW-1:0]            lat_w_reg;
    logic [HW-1:0]            lat_h_reg;
    logic [CW-1:0]            in_col_reg;
    logic [HW-1:0]            in_row_reg;
    logic [CW-1:0]            out_col_reg;
    logic [HW-1:0]            out_row_reg;
    logic [AW-1:0]            wptr_reg;
    logic [AW-1:0]            optr_reg;
    logic [3:0]               rd_cnt_reg;
    logic                     tap_ok_reg;
    logic                     tap_ctr_reg;
    logic [bbb_pkg::CNT_W-1:0] count_reg;
    logic [7:0]               alpha_reg;
    logic                     m_tvalid_reg;
    logic [31:0]              m_tdata_reg;
    logic                     m_tlast_reg;

    // datapath
    logic                     accept;
    logic                     start;
    logic                     in_done;
    logic                     pix_take;
    logic                     emit;
    logic [WW-1:0]            w_eff;
    logic [HW-1:0]            h_eff;
    logic [WW-1:0]            clamp_w;
    logic [HW-1:0]            clamp_h;
    logic [1:0]               dy;
    logic [1:0]               dx;
    logic                     tap_ok;
    logic signed [SW-1:0]     addr_sum;
    logic signed [SW-1:0]     addr_fix;
    logic [AW-1:0]            raddr;
    logic [31:0]              rdata;
    logic                     out_load;
    logic                     frame_end;
    logic [CW-1:0]            out_col_next;
    logic [HW-1:0]            out_row_next;
    logic [AW-1:0]            optr_next;
    bbb_pkg::lane_ctl_t       lane_ctl;
    logic [7:0]               lane_res [3];

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= bbb_pkg::WIDTH_RST;
            height_reg   <= bbb_pkg::HEIGHT_RST;
            strength_reg <= bbb_pkg::STRENGTH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bbb_pkg::REG_WIDTH:    width_reg    <= pwdata[DW-1:0];
                bbb_pkg::REG_HEIGHT:   height_reg   <= pwdata[DW-1:0];
                bbb_pkg::REG_STRENGTH: strength_reg <= pwdata[bbb_pkg::STR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bbb_pkg::REG_WIDTH:    prdata = 32'(width_reg);
            bbb_pkg::REG_HEIGHT:   prdata = 32'(height_reg);
            bbb_pkg::REG_STRENGTH: prdata = 32'(strength_reg);
            default:               prdata = '0;
        endcase
    end

    // geometry clamped to the supported range
    always_comb
    begin
        if (width_reg == '0)
            clamp_w = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            clamp_w = WW'(MAX_WIDTH);
        else
            clamp_w = WW'(width_reg);
        if (height_reg == '0)
            clamp_h = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            clamp_h = HW'(MAX_HEIGHT);
        else
            clamp_h = HW'(height_reg);
    end

    // input decode
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign start    = (in_row_reg == '0) && (in_col_reg == '0);
    assign in_done  = (in_row_reg >= lat_h_reg) && !start;
    assign pix_take = accept && (s_tuser == bbb_pkg::OP_PIXEL) && !in_done;
    assign w_eff    = start ? clamp_w : lat_w_reg;
    assign h_eff    = start ? clamp_h : lat_h_reg;
    assign emit     = (in_row_reg >= HW'(2)) || ((in_row_reg == HW'(1)) && (in_col_reg != '0));

    // tap address: out pointer + (dy-1)*width + (dx-1), wrapped into the ring
    always_comb
    begin
        case (rd_cnt_reg)
            4'd0, 4'd1, 4'd2: dy = 2'd0;
            4'd3, 4'd4, 4'd5: dy = 2'd1;
            default:          dy = 2'd2;
        endcase
        case (rd_cnt_reg)
            4'd0, 4'd3, 4'd6: dx = 2'd0;
            4'd1, 4'd4, 4'd7: dx = 2'd1;
            default:          dx = 2'd2;
        endcase
        addr_sum = $signed(SW'(optr_reg)) + $signed(SW'(dx)) - $signed(SW'(1));
        case (dy)
            2'd0:    addr_sum = addr_sum - $signed(SW'(lat_w_reg));
            2'd2:    addr_sum = addr_sum + $signed(SW'(lat_w_reg));
            default: ;
        endcase
        if (addr_sum < 0)
            addr_fix = addr_sum + $signed(SW'(RING));
        else if (addr_sum >= $signed(SW'(RING)))
            addr_fix = addr_sum - $signed(SW'(RING));
        else
            addr_fix = addr_sum;
        raddr  = addr_fix[AW-1:0];
        tap_ok = 1'b1;
        if (dy == 2'd0 && out_row_reg == '0)
            tap_ok = 1'b0;
        if (dy == 2'd2 && (out_row_reg + HW'(1)) >= lat_h_reg)
            tap_ok = 1'b0;
        if (dx == 2'd0 && out_col_reg == '0)
            tap_ok = 1'b0;
        if (dx == 2'd2 && (WW'(out_col_reg) + WW'(1)) >= lat_w_reg)
            tap_ok = 1'b0;
    end

    // line store
    bbb_ram #(
        .WIDTH (32),
        .DEPTH (RING)
    ) u_line_store (
        .clk   (clk),
        .we    (pix_take),
        .waddr (wptr_reg),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // lane control
    always_comb
    begin
        lane_ctl.clr      = (state_reg == S_IDLE);
        lane_ctl.acc      = (state_reg == S_READ) && (rd_cnt_reg != '0) && tap_ok_reg;
        lane_ctl.centre   = (state_reg == S_READ) && (rd_cnt_reg != '0) && tap_ctr_reg;
        lane_ctl.div_en   = (state_reg == S_DIV);
        lane_ctl.recip    = bbb_pkg::recip(count_reg);
        lane_ctl.strength = $signed(strength_reg);
    end

    // three colour lanes side by side
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        bbb_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .tap    (rdata[8*g +: 8]),
            .result (lane_res[g])
        );
    end

    // output position advance
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign frame_end = (out_row_reg == lat_h_reg - HW'(1))
                    && (WW'(out_col_reg) == lat_w_reg - WW'(1));
    assign optr_next = (optr_reg == AW'(RING - 1)) ? '0 : optr_reg + AW'(1);

    always_comb
    begin
        if ((WW'(out_col_reg) + WW'(1)) >= lat_w_reg)
        begin
            out_col_next = '0;
            out_row_next = out_row_reg + HW'(1);
        end
        else
        begin
            out_col_next = out_col_reg + CW'(1);
            out_row_next = out_row_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lat_w_reg    <= WW'(1);
            lat_h_reg    <= HW'(1);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            wptr_reg     <= '0;
            optr_reg     <= '0;
            rd_cnt_reg   <= '0;
            tap_ok_reg   <= 1'b0;
            tap_ctr_reg  <= 1'b0;
            count_reg    <= '0;
            alpha_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rd_cnt_reg <= '0;
                    count_reg  <= '0;
                    if (pix_take)
                    begin
                        if (start)
                        begin
                            lat_w_reg <= clamp_w;
                            lat_h_reg <= clamp_h;
                        end
                        if ((WW'(in_col_reg) + WW'(1)) >= w_eff)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + HW'(1);
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + CW'(1);
                        end
                        wptr_reg <= (wptr_reg == AW'(RING - 1)) ? '0 : wptr_reg + AW'(1);
                        if (emit && h_eff != '0)
                        begin
                            state_reg <= S_READ;
                        end
                    end
                    else if (accept && s_tuser == bbb_pkg::OP_DRAIN && in_done
                             && out_row_reg < lat_h_reg)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_cnt_reg  <= rd_cnt_reg + 4'd1;
                    tap_ok_reg  <= tap_ok;
                    tap_ctr_reg <= (rd_cnt_reg == 4'd4);
                    if (lane_ctl.acc)
                    begin
                        count_reg <= count_reg + bbb_pkg::CNT_W'(1);
                    end
                    if (lane_ctl.centre)
                    begin
                        alpha_reg <= rdata[31:24];
                    end
                    if (rd_cnt_reg == 4'd9)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {alpha_reg, lane_res[2], lane_res[1], lane_res[0]};
                        m_tlast_reg  <= frame_end;
                        state_reg    <= S_IDLE;
                        if (out_row_next >= lat_h_reg)
                        begin
                            // last result out: back to frame start
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            wptr_reg    <= '0;
                            optr_reg    <= '0;
                        end
                        else
                        begin
                            out_col_reg <= out_col_next;
                            out_row_reg <= out_row_next;
                            optr_reg    <= optr_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // divide never sees an empty neighbourhood
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (count_reg >= 4'd1 && count_reg <= 4'd9))
        else $error("neighbourhood count out of range");

    // ring pointers stay inside the line store
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg < AW'(RING)) && (optr_reg < AW'(RING)))
        else $error("line store pointer out of range");

    // output position never overtakes the frame
    a_out_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_row_reg < lat_h_reg) || (out_row_reg == '0))
        else $error("output row beyond frame");

    // a result is only loaded after a full read sweep
    a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> $past(rd_cnt_reg) == 4'd9)
        else $error("divide entered before all taps read");
`endif

endmodule
